// File: hw/rtl/bls_pkg.sv
`default_nettype none

package bls_pkg;

  // Coordinate and decision-value widths
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 4;

  // Action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  // Input word
  typedef struct packed {
    logic   action;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_t;

  // Result word
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_valid;
    logic   last_point;
  } out_t;

  // Classified command from the front end to the stepping engine
  typedef struct packed {
    logic   is_start;
    coord_t x0;
    coord_t y0;
    coord_t tx;
    coord_t ty;
    logic   x_neg;
    logic   y_neg;
    logic   x_major;
    logic   single;
    err_t   err;
    err_t   keep;
    err_t   move;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/bls_fifo.sv
`default_nettype none

module bls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] data_in,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] data_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_in;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bls_front.sv
`default_nettype none

module bls_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire bls_pkg::in_t in_word,
  output logic             cmd_push,
  input  wire logic        cmd_full,
  output bls_pkg::cmd_t    cmd_word
);

  import bls_pkg::*;

  logic   valid_r, valid_nxt;
  logic   action_r;
  coord_t xs_r, ys_r, xe_r, ye_r;
  delta_t dx_r, dy_r;
  logic   accept;

  mag_t   mx, my, major, minor;
  delta_t ax, ay;
  logic   x_major;
  err_t   keep_w;

  // Holding stage: drains into the command queue when it has room
  assign cmd_push = valid_r && !cmd_full;
  assign full     = valid_r && cmd_full;
  assign accept   = push && !full;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (cmd_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture endpoints and signed deltas
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_word.action;
      xs_r     <= in_word.x_start;
      ys_r     <= in_word.y_start;
      xe_r     <= in_word.x_end;
      ye_r     <= in_word.y_end;
      dx_r     <= delta_t'(in_word.x_end) - delta_t'(in_word.x_start);
      dy_r     <= delta_t'(in_word.y_end) - delta_t'(in_word.y_start);
    end
  end

  // Classify: magnitudes, directions, major axis, error increments
  always_comb begin
    ax      = dx_r[COORD_BITS] ? -dx_r : dx_r;
    ay      = dy_r[COORD_BITS] ? -dy_r : dy_r;
    mx      = ax[COORD_BITS-1:0];
    my      = ay[COORD_BITS-1:0];
    x_major = (mx > my);
    major   = x_major ? mx : my;
    minor   = x_major ? my : mx;
    keep_w  = err_t'({minor, 1'b0});

    cmd_word.is_start = (action_r == ACT_START);
    cmd_word.x0       = xs_r;
    cmd_word.y0       = ys_r;
    cmd_word.tx       = xe_r;
    cmd_word.ty       = ye_r;
    cmd_word.x_neg    = dx_r[COORD_BITS];
    cmd_word.y_neg    = dy_r[COORD_BITS];
    cmd_word.x_major  = x_major;
    cmd_word.single   = (dx_r == '0) && (dy_r == '0);
    cmd_word.keep     = keep_w;
    cmd_word.move     = keep_w - err_t'({major, 1'b0});
    cmd_word.err      = keep_w - err_t'(major);
  end

endmodule

`default_nettype wire

// File: hw/rtl/bls_back.sv
`default_nettype none

module bls_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  input  wire bls_pkg::cmd_t cmd_word,
  output logic               res_push,
  input  wire logic          res_full,
  output bls_pkg::out_t      res_word
);

  import bls_pkg::*;

  localparam coord_t STEP_POS = coord_t'(1);
  localparam coord_t STEP_NEG = coord_t'(-1);

  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t tx_r, ty_r;
  err_t   err_r, err_nxt, keep_r, move_r;
  logic   x_neg_r, y_neg_r, x_major_r;
  logic   active_r, active_nxt;

  logic   move_minor;
  coord_t x_adv, y_adv;
  logic   done;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  // One command per cycle: load a new line or advance one pixel
  always_comb begin
    move_minor = !err_r[ERR_BITS-1] && (err_r != '0);
    x_adv      = cur_x_r + (x_neg_r ? STEP_NEG : STEP_POS);
    y_adv      = cur_y_r + (y_neg_r ? STEP_NEG : STEP_POS);

    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    active_nxt = active_r;
    done       = 1'b0;
    res_word   = '0;

    if (cmd_word.is_start) begin
      cur_x_nxt            = cmd_word.x0;
      cur_y_nxt            = cmd_word.y0;
      err_nxt              = cmd_word.err;
      active_nxt           = !cmd_word.single;
      res_word.point_x     = cmd_word.x0;
      res_word.point_y     = cmd_word.y0;
      res_word.point_valid = 1'b1;
      res_word.last_point  = cmd_word.single;
    end else if (active_r) begin
      err_nxt = err_r + (move_minor ? move_r : keep_r);
      if (x_major_r) begin
        cur_x_nxt = x_adv;
        cur_y_nxt = move_minor ? y_adv : cur_y_r;
        done      = (x_adv == tx_r);
      end else begin
        cur_y_nxt = y_adv;
        cur_x_nxt = move_minor ? x_adv : cur_x_r;
        done      = (y_adv == ty_r);
      end
      active_nxt           = !done;
      res_word.point_x     = cur_x_nxt;
      res_word.point_y     = cur_y_nxt;
      res_word.point_valid = 1'b1;
      res_word.last_point  = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd_pop) begin
      active_r <= active_nxt;
    end
  end

  // Line state, loaded on start and walked on steps
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
      if (cmd_word.is_start) begin
        tx_r      <= cmd_word.tx;
        ty_r      <= cmd_word.ty;
        keep_r    <= cmd_word.keep;
        move_r    <= cmd_word.move;
        x_neg_r   <= cmd_word.x_neg;
        y_neg_r   <= cmd_word.y_neg;
        x_major_r <= cmd_word.x_major;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bresenham_line_stepper.sv
`default_nettype none

// Bresenham line stepper for all octants. Push a start word (action 0) with
// two endpoints to begin a line: the start point comes back at once. Each
// step word (action 1) returns the next pixel along the line, with
// last_point set on the end point; a step with no line in progress returns
// a word with point_valid 0 and all other fields 0. A start word drops any
// line in progress. One word is accepted and one result produced per clock
// when pop is held high; a word is registered in the front holding stage,
// the command queue and the result queue, in that order, before its result
// shows. The rate is set by the stepping engine, which updates the error
// term and the current pixel once for each word. CMD_DEPTH and OUT_DEPTH size
// the queues between front end and engine and in front of the result port.
module bresenham_line_stepper #(
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire bls_pkg::in_t in_word,
  output logic              empty,
  input  wire logic         pop,
  output bls_pkg::out_t     out_word
);

  import bls_pkg::*;

  cmd_t fe_cmd, be_cmd;
  logic fe_push, cmdq_full, cmdq_empty, be_pop;
  out_t be_res;
  logic be_push, resq_full;

  // Front end: capture and classify
  bls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .cmd_push (fe_push),
    .cmd_full (cmdq_full),
    .cmd_word (fe_cmd)
  );

  // Command queue
  bls_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .full     (cmdq_full),
    .data_in  (fe_cmd),
    .pop      (be_pop),
    .empty    (cmdq_empty),
    .data_out (be_cmd)
  );

  // Stepping engine
  bls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (be_pop),
    .cmd_word  (be_cmd),
    .res_push  (be_push),
    .res_full  (resq_full),
    .res_word  (be_res)
  );

  // Result queue
  bls_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (be_push),
    .full     (resq_full),
    .data_in  (be_res),
    .pop      (pop),
    .empty    (empty),
    .data_out (out_word)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bls_checker.sv
`default_nettype none

module bls_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          full,
  input wire logic          empty,
  input wire logic          pop,
  input wire bls_pkg::out_t out_word
);

  // Queues come out of reset empty
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk)
    !rst_n |=> !full)
    else $error("input side full after reset");

  // A word with no pixel carries zero fields
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_word.point_valid) |->
      (out_word.point_x == '0) && (out_word.point_y == '0) && !out_word.last_point)
    else $error("empty-step word carries non-zero fields");

  // Last point only on a real pixel
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.last_point) |-> out_word.point_valid)
    else $error("last_point without point_valid");

  // Waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result changed before pop");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_word (out_word)
);

`default_nettype wire
